>>> sv/scc_pkg.sv
// ----------------------------------------------------------------------------
// Spherical/cylindrical converter package
// Shared widths, arctangent table, stage types and the per-stage CORDIC step.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int unsigned LEN_W    = 32;
  localparam int unsigned GUARD    = 16;
  localparam int unsigned XW       = LEN_W + GUARD + 4;
  localparam int unsigned ZW       = 34;
  localparam int unsigned ATAN_W   = 30;
  localparam int unsigned ATAN_LEN = 40;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned KW       = 31;
  localparam int unsigned MAG_W    = XW - 1;
  localparam int unsigned HI_W     = MAG_W - LEN_W;
  localparam int unsigned HP_W     = HI_W + KW;
  localparam int unsigned LP_W     = LEN_W + KW;
  localparam int unsigned PROD_W   = HP_W + 3;
  localparam int unsigned RND_W    = PROD_W + 1;
  localparam int unsigned Q_W      = RND_W - GUARD;

  localparam logic OP_SPH_TO_CYL = 1'b0;
  localparam logic OP_CYL_TO_SPH = 1'b1;

  localparam logic [ATAN_W-1:0] ATAN_TABLE [ATAN_LEN] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
    30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
    30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
    30'd20, 30'd10, 30'd5, 30'd3, 30'd1,
    30'd1, 30'd0, 30'd0, 30'd0, 30'd0,
    30'd0, 30'd0, 30'd0, 30'd0, 30'd0
  };

  typedef struct packed {
    logic                 op;
    logic                 zero;
    logic                 flip;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [LEN_W-1:0]     phi;
  } cordic_t;

  typedef struct packed {
    logic             op;
    logic [LEN_W-1:0] ang;
    logic [LEN_W-1:0] phi;
  } meta_t;

  typedef struct packed {
    meta_t            meta;
    logic             neg_x;
    logic [MAG_W-1:0] mag_x;
    logic             neg_y;
    logic [MAG_W-1:0] mag_y;
  } abs_t;

  typedef struct packed {
    meta_t           meta;
    logic            neg_x;
    logic [HP_W-1:0] hi_x;
    logic [LP_W-1:0] lo_x;
    logic            neg_y;
    logic [HP_W-1:0] hi_y;
    logic [LP_W-1:0] lo_y;
  } mul_t;

  typedef struct packed {
    meta_t             meta;
    logic              neg_x;
    logic [PROD_W-1:0] prod_x;
    logic              neg_y;
    logic [PROD_W-1:0] prod_y;
  } sum_t;

  typedef struct packed {
    logic             sat;
    logic [LEN_W-1:0] value;
  } len_t;

  typedef struct packed {
    logic [LEN_W-1:0] out_a;
    logic [LEN_W-1:0] out_b;
    logic [LEN_W-1:0] out_phi;
    logic             saturated;
  } result_t;

  // Integer square root of the accumulated CORDIC gain squared (Q2.60).
  function automatic logic [63:0] gain_root(input int unsigned iters);
    logic [63:0] p;
    logic [63:0] res;
    logic [63:0] probe;
    p = 64'd1 << 60;
    for (int i = 0; i < ATAN_LEN; i++) begin
      if (i < iters && 2 * i < 64) begin
        p = p + (p >> (2 * i));
      end
    end
    res   = '0;
    probe = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (p >= res + probe) begin
        p   = p - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    if (res == '0) begin
      res = 64'd1;
    end
    return res;
  endfunction

  // One micro-rotation; rotation mode steers on z, vectoring mode on y.
  function automatic cordic_t cordic_step(input cordic_t s, input logic [IDX_W-1:0] iter);
    cordic_t              n;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] da;
    logic                 sigma;
    n     = s;
    dx    = s.y >>> iter;
    dy    = s.x >>> iter;
    da    = $signed({{(ZW - ATAN_W){1'b0}}, ATAN_TABLE[iter]});
    sigma = (s.op == OP_CYL_TO_SPH) ? s.y[XW-1] : ~s.z[ZW-1];
    if (sigma) begin
      n.x = s.x - dx;
      n.y = s.y + dy;
      n.z = s.z - da;
    end else begin
      n.x = s.x + dx;
      n.y = s.y - dy;
      n.z = s.z + da;
    end
    return n;
  endfunction

  // Rounds away the guard bits and clamps to the signed 32-bit range.
  function automatic len_t round_sat(input logic [PROD_W-1:0] prod, input logic neg);
    len_t             r;
    logic [RND_W-1:0] rnd;
    logic [Q_W-1:0]   q;
    rnd = RND_W'(prod) + (RND_W'(1) << (GUARD - 1));
    q   = rnd[RND_W-1:GUARD];
    r.sat = 1'b0;
    if (!neg) begin
      if (q > Q_W'(32'h7FFF_FFFF)) begin
        r.sat   = 1'b1;
        r.value = 32'h7FFF_FFFF;
      end else begin
        r.value = q[LEN_W-1:0];
      end
    end else begin
      if (q > Q_W'(32'h8000_0000)) begin
        r.sat   = 1'b1;
        r.value = 32'h8000_0000;
      end else begin
        r.value = ~q[LEN_W-1:0] + 32'd1;
      end
    end
    return r;
  endfunction

endpackage

>>> sv/spherical_cylindrical_converter_top.sv
// ----------------------------------------------------------------------------
// Spherical/cylindrical coordinate converter
// Pipelined CORDIC that turns (r, theta) into (z, rho) and back, phi passed on.
// ----------------------------------------------------------------------------
//  Channel   Direction  tdata (low bit first)          tuser
//  s_axis    in         in_a, in_b, in_phi (96 bits)    operation
//  m_axis    out        out_a, out_b, out_phi (96 bits) saturated
//
// One transaction is accepted per cycle while s_axis_tready is high; a result passes
// through the input register, one CORDIC micro-rotation per stage, and then the
// magnitude, multiply, sum and output stages. Reset clears only the valid bits.
// When the output is held, one further result is caught in a skid register and
// s_axis_tready falls in the following cycle; the whole pipeline then holds.
module spherical_cylindrical_converter_top #(
  parameter int unsigned ITERATIONS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // in_a [31:0], in_b [63:32], in_phi [95:64]
  input  logic        s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,  // out_a [31:0], out_b [63:32], out_phi [95:64]
  output logic        m_axis_tuser   // saturated
);

  localparam int unsigned XW    = scc_pkg::XW;
  localparam int unsigned ZW    = scc_pkg::ZW;
  localparam int unsigned LEN_W = scc_pkg::LEN_W;
  localparam int unsigned GUARD = scc_pkg::GUARD;
  localparam int unsigned MAG_W = scc_pkg::MAG_W;
  localparam int unsigned HP_W  = scc_pkg::HP_W;
  localparam int unsigned LP_W  = scc_pkg::LP_W;
  localparam int unsigned PROD_W = scc_pkg::PROD_W;
  localparam int unsigned KW    = scc_pkg::KW;
  localparam int unsigned IDX_W = scc_pkg::IDX_W;

  localparam logic [63:0]   GainRoot = scc_pkg::gain_root(ITERATIONS);
  localparam logic [63:0]   KFull    = (64'd1 << 60) / GainRoot;
  localparam logic [KW-1:0] K        = KFull[KW-1:0];

  logic en;

  scc_pkg::cordic_t st_in;
  scc_pkg::cordic_t st_d [ITERATIONS+1];
  scc_pkg::cordic_t st_q [ITERATIONS+1];
  logic [ITERATIONS:0] v_q;

  scc_pkg::abs_t   abs_d, abs_q;
  scc_pkg::mul_t   mul_d, mul_q;
  scc_pkg::sum_t   sum_d, sum_q;
  logic            va_q, vb_q, vc_q;

  scc_pkg::len_t    len_x, len_y;
  scc_pkg::result_t res_d, out_q, skid_q;
  logic             out_valid_q, skid_valid_q;
  logic             push, take;

  logic [LEN_W-1:0]     in_a, in_b;
  logic signed [XW-1:0] a_ext, b_ext;

  assign en            = ~skid_valid_q;
  assign s_axis_tready = en;

  always_comb begin
    in_a  = s_axis_tdata[31:0];
    in_b  = s_axis_tdata[63:32];
    a_ext = $signed({{(XW - LEN_W - GUARD){in_a[LEN_W-1]}}, in_a, {GUARD{1'b0}}});
    b_ext = $signed({{(XW - LEN_W - GUARD){in_b[LEN_W-1]}}, in_b, {GUARD{1'b0}}});
    st_in.op   = s_axis_tuser;
    st_in.phi  = s_axis_tdata[95:64];
    st_in.zero = (s_axis_tuser == scc_pkg::OP_CYL_TO_SPH) && (in_a == '0) && (in_b == '0);
    if (s_axis_tuser == scc_pkg::OP_CYL_TO_SPH) begin
      st_in.flip = in_a[LEN_W-1];
      st_in.y    = st_in.flip ? -b_ext : b_ext;
      st_in.z    = '0;
    end else begin
      st_in.flip = in_b[LEN_W-1] ^ in_b[LEN_W-2];
      st_in.y    = '0;
      st_in.z    = $signed({{(ZW - LEN_W + 1){in_b[LEN_W-1] ^ st_in.flip}},
                            in_b[LEN_W-2:0]});
    end
    st_in.x = st_in.flip ? -a_ext : a_ext;
  end

  always_comb begin
    st_d[0] = st_in;
    for (int i = 0; i < ITERATIONS; i++) begin
      st_d[i+1] = scc_pkg::cordic_step(st_q[i], IDX_W'(i));
    end
  end

  always_comb begin
    scc_pkg::cordic_t last;
    last = st_q[ITERATIONS];
    abs_d.meta.op  = last.op;
    abs_d.meta.phi = last.phi;
    abs_d.meta.ang = last.zero ? '0 : {last.z[LEN_W-1] ^ last.flip, last.z[LEN_W-2:0]};
    abs_d.neg_x    = last.x[XW-1];
    abs_d.mag_x    = last.x[XW-1] ? MAG_W'(-last.x) : MAG_W'(last.x);
    abs_d.neg_y    = last.y[XW-1];
    abs_d.mag_y    = last.y[XW-1] ? MAG_W'(-last.y) : MAG_W'(last.y);
  end

  always_comb begin
    mul_d.meta  = abs_q.meta;
    mul_d.neg_x = abs_q.neg_x;
    mul_d.hi_x  = HP_W'(abs_q.mag_x[MAG_W-1:LEN_W]) * HP_W'(K);
    mul_d.lo_x  = LP_W'(abs_q.mag_x[LEN_W-1:0]) * LP_W'(K);
    mul_d.neg_y = abs_q.neg_y;
    mul_d.hi_y  = HP_W'(abs_q.mag_y[MAG_W-1:LEN_W]) * HP_W'(K);
    mul_d.lo_y  = LP_W'(abs_q.mag_y[LEN_W-1:0]) * LP_W'(K);
  end

  always_comb begin
    sum_d.meta   = mul_q.meta;
    sum_d.neg_x  = mul_q.neg_x;
    sum_d.prod_x = (PROD_W'(mul_q.hi_x) << 2) + PROD_W'(mul_q.lo_x >> 30);
    sum_d.neg_y  = mul_q.neg_y;
    sum_d.prod_y = (PROD_W'(mul_q.hi_y) << 2) + PROD_W'(mul_q.lo_y >> 30);
  end

  always_comb begin
    len_x = scc_pkg::round_sat(sum_q.prod_x, sum_q.neg_x);
    len_y = scc_pkg::round_sat(sum_q.prod_y, sum_q.neg_y);
    res_d.out_a   = len_x.value;
    res_d.out_phi = sum_q.meta.phi;
    if (sum_q.meta.op == scc_pkg::OP_CYL_TO_SPH) begin
      res_d.out_b     = sum_q.meta.ang;
      res_d.saturated = len_x.sat;
    end else begin
      res_d.out_b     = len_y.value;
      res_d.saturated = len_x.sat | len_y.sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en) begin
      v_q  <= {v_q[ITERATIONS-1:0], s_axis_tvalid};
      va_q <= v_q[ITERATIONS];
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i <= ITERATIONS; i++) begin
        st_q[i] <= st_d[i];
      end
      abs_q <= abs_d;
      mul_q <= mul_d;
      sum_q <= sum_d;
    end
  end

  assign push = vc_q & en;
  assign take = out_valid_q & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_valid_q && !take) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.out_phi, out_q.out_b, out_q.out_a};
  assign m_axis_tuser  = out_q.saturated;

  a_skid_needs_held_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready))
    else $error("skid register filled while the output was free");

  a_skid_implies_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result behind an empty output");

  a_pipeline_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |=> $stable(vc_q) && $stable(v_q))
    else $error("pipeline moved while the skid register was full");

endmodule
